// ----- hw/rtl/wrc_pkg.sv -----
`default_nettype none
package wrc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int ID_W = 8;
  localparam int WT_W = 16;
  localparam int FRAC_W = 17;
  localparam int TOT_W = $clog2(MAX_ENTRIES * ((1 << WT_W) - 1) + 1);
  localparam int TGT_W = TOT_W + FRAC_W;
  localparam int CMD_W = 2;
  localparam int ST_W = 2;
  localparam int OUT_CNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHOOSE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    logic hit;
    logic match;
  } scan_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/wrc_slots.sv -----
`default_nettype none
module wrc_slots
  import wrc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [ID_W-1:0]  wr_id,
  input  wire logic [WT_W-1:0]  wr_weight,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [ID_W-1:0]  rd_id,
  output logic      [WT_W-1:0]  rd_weight
);

  logic [ID_W-1:0] slot_ids [MAX_ENTRIES];
  logic [WT_W-1:0] slot_weights [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_ids[wr_addr] <= wr_id;
      slot_weights[wr_addr] <= wr_weight;
    end
    rd_id <= slot_ids[rd_addr];
    rd_weight <= slot_weights[rd_addr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/wrc_scan_unit.sv -----
`default_nettype none
module wrc_scan_unit
  import wrc_pkg::*;
(
  input  wire logic             clk,
  input  wire scan_ctl_t        ctl,
  input  wire logic [ID_W-1:0]  rd_id,
  input  wire logic [WT_W-1:0]  rd_weight,
  input  wire logic [ID_W-1:0]  key_id,
  input  wire logic [TGT_W-1:0] target,
  output scan_stat_t            stat
);

  logic [TOT_W-1:0] prefix;
  logic [TOT_W-1:0] prefix_next;

  assign prefix_next = prefix + TOT_W'(rd_weight);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      prefix <= '0;
    end else if (ctl.step) begin
      prefix <= prefix_next;
    end
  end

  always_comb begin
    stat.hit = TGT_W'({prefix_next, 16'h0000}) >= target;
    stat.match = rd_id == key_id;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/weighted_random_choice_table_unit.sv -----
// weighted random choice table, one command beat in, one result beat out
// input channel s_*: s_tuser carries the command (insert, remove, choose),
//   s_tdata carries entry id, entry weight and random fraction
// output channel m_*: status, chosen id and entry count after the command
// a command is taken only when the block is idle; s_tready is low while it works
// path from input beat to result beat:
//   insert: straight to the result register
//   remove: id search, then compaction
//   choose: one multiply, then a prefix scan over the entries
// the next command is taken the cycle after a result is loaded, so commands
// are handled one at a time
// the scan speed is set by the slot storage, read at one slot per cycle through
// a shared prefix adder and compare unit
// the result sits in an output register; the next command may be taken while
// it waits, and a later result holds until the receiver takes the earlier one
// reset empties the table and drops any pending result; slot contents are
// not cleared and need no clearing pass
`default_nettype none
module weighted_random_choice_table_unit
  import wrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // entry_id, entry_weight, random_fraction
  input  wire logic [1:0]  s_tuser,  // cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata   // status, chosen_id, entry_count
);

  typedef enum logic [2:0] {
    IDLE,
    MULT,
    SCAN_RM,
    SHIFT,
    SCAN_CH,
    FINISH
  } state_t;

  state_t state;
  logic [CNT_W-1:0] count;
  logic [TOT_W-1:0] total;
  logic [IDX_W-1:0] idx;
  logic [ID_W-1:0] key_id;
  logic [FRAC_W-1:0] frac;
  logic [TGT_W-1:0] target;
  logic [ST_W-1:0] res_status;
  logic [ID_W-1:0] res_id;

  logic accept;
  logic [ID_W-1:0] in_id;
  logic [WT_W-1:0] in_weight;
  logic [FRAC_W-1:0] in_frac;
  logic [CNT_W-1:0] idx_plus;
  logic not_full;

  logic wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ID_W-1:0] wr_id;
  logic [WT_W-1:0] wr_weight;
  logic [IDX_W-1:0] rd_addr;
  logic [ID_W-1:0] rd_id;
  logic [WT_W-1:0] rd_weight;
  scan_ctl_t ctl;
  scan_stat_t stat;

  assign s_tready = (state == IDLE) && !rst;
  assign accept = s_tvalid && s_tready;
  assign in_id = s_tdata[7:0];
  assign in_weight = s_tdata[23:8];
  assign in_frac = s_tdata[40:24];
  assign idx_plus = CNT_W'(idx) + CNT_W'(1);
  assign not_full = count < CNT_W'(MAX_ENTRIES);

  // slot reads are registered, so the address runs one slot ahead
  always_comb begin
    wr_en = 1'b0;
    wr_addr = count[IDX_W-1:0];
    wr_id = in_id;
    wr_weight = in_weight;
    rd_addr = idx;
    if (state == SHIFT) begin
      wr_en = idx_plus < count;
      wr_addr = idx;
      wr_id = rd_id;
      wr_weight = rd_weight;
      rd_addr = idx + IDX_W'(2);
    end else if (state == SCAN_RM || state == SCAN_CH) begin
      rd_addr = idx_plus[IDX_W-1:0];
    end else if (state == IDLE) begin
      rd_addr = '0;
      if (accept && s_tuser == CMD_INSERT && not_full) begin
        wr_en = 1'b1;
      end
    end
    ctl.clear = state == MULT;
    ctl.step = state == SCAN_CH;
  end

  wrc_slots u_slots (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_id     (wr_id),
    .wr_weight (wr_weight),
    .rd_addr   (rd_addr),
    .rd_id     (rd_id),
    .rd_weight (rd_weight)
  );

  wrc_scan_unit u_scan (
    .clk       (clk),
    .ctl       (ctl),
    .rd_id     (rd_id),
    .rd_weight (rd_weight),
    .key_id    (key_id),
    .target    (target),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      total <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != FINISH) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            key_id <= in_id;
            frac <= in_frac;
            idx <= '0;
            res_id <= '0;
            unique case (s_tuser)
              CMD_INSERT: begin
                state <= FINISH;
                if (not_full) begin
                  count <= count + CNT_W'(1);
                  total <= total + TOT_W'(in_weight);
                  res_status <= ST_OK;
                end else begin
                  res_status <= ST_FULL;
                end
              end
              CMD_REMOVE: begin
                res_status <= ST_MISS;
                if (count != '0) begin
                  state <= SCAN_RM;
                end else begin
                  state <= FINISH;
                end
              end
              CMD_CHOOSE: begin
                res_status <= ST_MISS;
                if (count != '0) begin
                  state <= MULT;
                end else begin
                  state <= FINISH;
                end
              end
              default: begin
                res_status <= ST_MISS;
                state <= FINISH;
              end
            endcase
          end
        end
        MULT: begin
          target <= TGT_W'(frac * total);
          state <= SCAN_CH;
        end
        SCAN_RM: begin
          if (stat.match) begin
            total <= total - TOT_W'(rd_weight);
            state <= SHIFT;
          end else if (idx_plus == count) begin
            res_status <= ST_MISS;
            state <= FINISH;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        SHIFT: begin
          if (idx_plus < count) begin
            idx <= idx + IDX_W'(1);
          end else begin
            count <= count - CNT_W'(1);
            res_status <= ST_OK;
            state <= FINISH;
          end
        end
        SCAN_CH: begin
          if (stat.hit || idx_plus == count) begin
            res_status <= ST_OK;
            res_id <= rd_id;
            state <= FINISH;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {1'b0, OUT_CNT_W'(count), res_id, res_status};
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/wrc_checker.sv -----
`default_nettype none
module wrc_checker
  import wrc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid && (rst || s_tready))
    else $error("reset left a result pending or the block busy");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command taken while previous one still running");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ST_FULL |-> m_tdata[14:10] == 5'(MAX_ENTRIES))
    else $error("full status with table not full");

  a_miss_no_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[9:2] == 8'h00)
    else $error("id reported on failed command");

endmodule

bind weighted_random_choice_table_unit wrc_checker u_wrc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wrc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [ST_W-1:0]      status;
    logic [ID_W-1:0]      chosen_id;
    logic [OUT_CNT_W-1:0] entry_count;
  } table_result_t;

  // shadow copy of the weighted table and the results it must produce
  class choice_table_tracker;
    logic [ID_W-1:0]  ids[MAX_ENTRIES];
    logic [WT_W-1:0]  weights[MAX_ENTRIES];
    int unsigned      count;
    logic [TOT_W-1:0] total;
    table_result_t    pending_results[$];
    int unsigned      failures;

    function new();
      count = 0;
      total = '0;
      failures = 0;
    endfunction

    function void take_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                               logic [WT_W-1:0] wt, logic [FRAC_W-1:0] frac);
      table_result_t res;
      logic [63:0]   target;
      logic [63:0]   prefix;
      int            hit;
      res.status = ST_MISS;
      res.chosen_id = '0;
      hit = -1;
      case (cmd)
        CMD_INSERT: begin
          if (count >= MAX_ENTRIES) begin
            res.status = ST_FULL;
          end else begin
            ids[count] = id;
            weights[count] = wt;
            count++;
            total += wt;
            res.status = ST_OK;
          end
        end
        CMD_REMOVE: begin
          for (int i = 0; i < count; i++)
            if (hit < 0 && ids[i] == id) hit = i;
          if (hit >= 0) begin
            total -= weights[hit];
            for (int k = hit; k + 1 < count; k++) begin
              ids[k] = ids[k + 1];
              weights[k] = weights[k + 1];
            end
            count--;
            res.status = ST_OK;
          end
        end
        CMD_CHOOSE: begin
          if (count != 0) begin
            target = 64'(frac) * 64'(total);
            prefix = '0;
            res.status = ST_OK;
            // saturate to the last entry when no prefix reaches the target
            res.chosen_id = ids[count - 1];
            for (int i = 0; i < count; i++) begin
              prefix += 64'(weights[i]);
              if (hit < 0 && (prefix << 16) >= target) begin
                hit = i;
                res.chosen_id = ids[i];
              end
            end
          end
        end
        default: ;
      endcase
      res.entry_count = OUT_CNT_W'(count);
      pending_results = {pending_results, res};
    endfunction

    function void check_result(logic [15:0] data);
      table_result_t want;
      if (pending_results.size() == 0) begin
        $error("result beat with no command outstanding: %h", data);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      if (data[1:0] !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, data[1:0]);
        failures++;
      end
      if (data[9:2] !== want.chosen_id) begin
        $error("chosen_id: expected %0d, got %0d", want.chosen_id, data[9:2]);
        failures++;
      end
      if (data[14:10] !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, data[14:10]);
        failures++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;

  choice_table_tracker tracker;

  weighted_random_choice_table_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // result side: random stalls, check every accepted beat
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata);
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                              logic [WT_W-1:0] wt, logic [FRAC_W-1:0] frac);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'd0, frac, wt, id};
    do @(posedge clk); while (!s_tready);
    tracker.take_command(cmd, id, wt, frac);
  endtask

  task automatic run_random(int unsigned n);
    int unsigned      done;
    int unsigned      roll;
    int unsigned      ins_pct;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    logic [WT_W-1:0]  wt;
    logic [FRAC_W-1:0] frac;
    done = 0;
    while (done < n) begin
      roll = $urandom_range(99);
      ins_pct = tracker.count < 4 ? 60 : (tracker.count > 12 ? 25 : 40);
      if (roll < 2) cmd = CMD_UNUSED;
      else if (roll < 2 + ins_pct) cmd = CMD_INSERT;
      else if (roll < 32 + ins_pct) cmd = CMD_CHOOSE;
      else cmd = CMD_REMOVE;

      // small id pool so removes hit and duplicates occur
      id = ($urandom_range(99) < 30) ? 8'($urandom) : 8'($urandom_range(23));
      if (cmd == CMD_REMOVE && tracker.count != 0 && $urandom_range(99) < 75)
        id = tracker.ids[$urandom_range(tracker.count - 1)];

      roll = $urandom_range(99);
      if (roll < 25) wt = 16'($urandom_range(15));
      else if (roll < 35) wt = 16'hFFFF;
      else if (roll < 40) wt = '0;
      else wt = 16'($urandom);

      roll = $urandom_range(99);
      if (roll < 10) frac = $urandom_range(1) ? 17'd65536 : 17'd0;
      else if (roll < 30) frac = 17'($urandom_range(131071));
      else frac = 17'($urandom_range(65536));

      send_command(cmd, id, wt, frac);
      if (cmd != CMD_UNUSED) done++;
    end
  endtask

  initial begin
    tracker = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corner cases
    send_command(CMD_CHOOSE, 8'h00, 16'h0000, 17'd65536);   // choose on empty table
    send_command(CMD_REMOVE, 8'h05, 16'hFFFF, 17'h1FFFF);   // remove on empty table
    send_command(CMD_UNUSED, 8'hFF, 16'hFFFF, 17'h1FFFF);
    send_command(CMD_INSERT, 8'h00, 16'h0000, 17'd0);
    send_command(CMD_INSERT, 8'hFF, 16'h0000, 17'd0);
    send_command(CMD_CHOOSE, 8'hFF, 16'h0000, 17'd65536);   // all weights zero
    send_command(CMD_INSERT, 8'hFF, 16'hFFFF, 17'd0);       // duplicate id
    send_command(CMD_REMOVE, 8'hFF, 16'h0000, 17'd0);       // takes earliest duplicate
    for (int i = 1; i <= 14; i++)
      send_command(CMD_INSERT, 8'(i * 17), 16'hFFFF - 16'(i), 17'd0);
    send_command(CMD_INSERT, 8'h42, 16'h1234, 17'd0);       // table full
    send_command(CMD_CHOOSE, 8'h00, 16'h0000, 17'd0);
    send_command(CMD_CHOOSE, 8'h00, 16'h0000, 17'd65536);
    send_command(CMD_CHOOSE, 8'h00, 16'h0000, 17'h1FFFF);   // fraction above one
    send_command(CMD_REMOVE, 8'h01, 16'h0000, 17'd0);       // id not held

    send_idle = 12;
    recv_idle = 52;
    run_random(500);
    send_idle = 52;
    recv_idle = 12;
    run_random(500);
    send_idle = 0;
    recv_idle = 0;
    run_random(500);
    s_tvalid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
